### design/bctl_pkg.sv
`timescale 1ns / 1ps

package bctl_pkg;

    localparam int MAX_GRID_W = 32;
    localparam int MAX_GRID_H = 32;
    localparam int MAX_POINTS = 64;

    localparam int HALF_COLS     = (MAX_GRID_W + 2) / 2;
    localparam int HALF_ROWS     = (MAX_GRID_H + 2) / 2;
    localparam int BANK_CORNERS  = HALF_COLS * HALF_ROWS;
    localparam int CADDR_W       = $clog2(BANK_CORNERS);
    localparam int SLOT_W        = $clog2(MAX_POINTS);
    localparam int BANK_POINTS   = BANK_CORNERS * MAX_POINTS;
    localparam int PADDR_W       = CADDR_W + SLOT_W;
    localparam int WEIGHT_W      = 23;
    localparam int PROD_W        = 16 + WEIGHT_W;
    localparam int SUM_W         = PROD_W + 2;

    localparam logic [1:0] OP_SET_LEN  = 2'd0;
    localparam logic [1:0] OP_WRITE_PT = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;

    localparam logic [1:0] REG_PYR_LEVEL   = 2'd0;
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  corner_col;
        logic [5:0]  corner_row;
        logic [5:0]  point_slot;
        logic [6:0]  curve_length;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [15:0] query_x;
        logic [15:0] query_y;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [15:0] cand_x;
        logic [15:0] cand_y;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [2:0] pyr_level;
        logic [5:0] grid_width;
        logic [5:0] grid_height;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_LEN,
        CMD_PT,
        CMD_QUERY,
        CMD_MISS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [1:0]                  bank_sel;
        logic [3:0][CADDR_W-1:0]     caddr;
        logic [SLOT_W-1:0]           slot;
        logic [6:0]                  length;
        logic [31:0]                 point;
        logic                        u0_par;
        logic                        v0_par;
        logic [10:0]                 du;
        logic [10:0]                 dv;
        logic [3:0]                  frac;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LEN,
        BK_RD,
        BK_MUL,
        BK_SUM,
        BK_MISS
    } back_state_t;

endpackage

### design/bctl_front.sv
`timescale 1ns / 1ps

module bctl_front (
    input  bctl_pkg::in_word_t   item,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  bctl_pkg::cfg_t       cfg,
    input  logic                 clear_done,
    input  bctl_pkg::fifo_stat_t fifo_stat,
    output logic                 push,
    output bctl_pkg::cmd_t       cmd
);

    function automatic logic [bctl_pkg::CADDR_W-1:0] corner_addr(
        input logic [5:0] row,
        input logic [5:0] col
    );
        logic [bctl_pkg::CADDR_W-1:0] r;
        logic [bctl_pkg::CADDR_W-1:0] c;
        r = bctl_pkg::CADDR_W'(row[5:1]);
        c = bctl_pkg::CADDR_W'(col[5:1]);
        return r * bctl_pkg::CADDR_W'(bctl_pkg::HALF_COLS) + c;
    endfunction

    logic [3:0]  frac;
    logic [15:0] mask;
    logic [15:0] u0_full;
    logic [15:0] v0_full;
    logic [5:0]  gw;
    logic [5:0]  gh;
    logic [4:0]  u0;
    logic [4:0]  v0;
    logic        corner_ok;
    logic        accept;

    always_comb
    begin
        logic [5:0] row;
        logic [5:0] col;
        row     = '0;
        col     = '0;
        frac    = 4'(cfg.pyr_level) + 4'd4;
        mask    = (16'd1 << frac) - 16'd1;
        u0_full = item.query_x >> frac;
        v0_full = item.query_y >> frac;
        gw = (cfg.grid_width > 6'(bctl_pkg::MAX_GRID_W)) ? 6'(bctl_pkg::MAX_GRID_W)
                                                         : cfg.grid_width;
        gh = (cfg.grid_height > 6'(bctl_pkg::MAX_GRID_H)) ? 6'(bctl_pkg::MAX_GRID_H)
                                                          : cfg.grid_height;
        u0 = u0_full[4:0];
        v0 = v0_full[4:0];
        corner_ok = (item.corner_col <= 6'(bctl_pkg::MAX_GRID_W))
                 && (item.corner_row <= 6'(bctl_pkg::MAX_GRID_H));

        item_ready = !fifo_stat.full && clear_done;
        accept     = item_valid && item_ready;

        cmd          = '0;
        cmd.kind     = bctl_pkg::CMD_MISS;
        cmd.bank_sel = {item.corner_row[0], item.corner_col[0]};
        cmd.slot     = item.point_slot[bctl_pkg::SLOT_W-1:0];
        cmd.length   = (item.curve_length > 7'(bctl_pkg::MAX_POINTS))
                       ? 7'(bctl_pkg::MAX_POINTS) : item.curve_length;
        cmd.point    = {item.point_y, item.point_x};
        cmd.u0_par   = u0[0];
        cmd.v0_par   = v0[0];
        cmd.du       = 11'(item.query_x & mask);
        cmd.dv       = 11'(item.query_y & mask);
        cmd.frac     = frac;
        push         = 1'b0;

        unique case (item.op)
            bctl_pkg::OP_SET_LEN, bctl_pkg::OP_WRITE_PT:
            begin
                for (int b = 0; b < 4; b++)
                begin
                    cmd.caddr[b] = corner_addr(item.corner_row, item.corner_col);
                end
                if (item.op == bctl_pkg::OP_SET_LEN)
                begin
                    cmd.kind = bctl_pkg::CMD_LEN;
                    push     = accept && corner_ok;
                end
                else
                begin
                    cmd.kind = bctl_pkg::CMD_PT;
                    push     = accept && corner_ok
                            && ({1'b0, item.point_slot} < 7'(bctl_pkg::MAX_POINTS));
                end
            end
            bctl_pkg::OP_QUERY:
            begin
                for (int b = 0; b < 4; b++)
                begin
                    row = (v0[0] == b[1]) ? {1'b0, v0} : {1'b0, v0} + 6'd1;
                    col = (u0[0] == b[0]) ? {1'b0, u0} : {1'b0, u0} + 6'd1;
                    cmd.caddr[b] = corner_addr(row, col);
                end
                if (u0_full >= 16'(gw) || v0_full >= 16'(gh))
                begin
                    cmd.kind = bctl_pkg::CMD_MISS;
                end
                else
                begin
                    cmd.kind = bctl_pkg::CMD_QUERY;
                end
                push = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

### design/bctl_fifo.sv
`timescale 1ns / 1ps

module bctl_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bctl_pkg::cmd_t       push_data,
    input  logic                 pop,
    output bctl_pkg::cmd_t       head,
    output bctl_pkg::fifo_stat_t stat
);

    bctl_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    always_comb
    begin
        head            = entry_reg[rd_ptr_reg];
        stat.full       = (count_reg == 2'd2);
        stat.head_valid = (count_reg != 2'd0);
        wr_ptr_next     = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next     = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next      = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/bctl_back.sv
`timescale 1ns / 1ps

module bctl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bctl_pkg::cmd_t       head,
    input  bctl_pkg::fifo_stat_t fifo_stat,
    output logic                 pop,
    output logic                 clear_done,
    output bctl_pkg::out_word_t  result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    localparam int CA = bctl_pkg::CADDR_W;
    localparam int PA = bctl_pkg::PADDR_W;
    localparam int WW = bctl_pkg::WEIGHT_W;
    localparam int PW = bctl_pkg::PROD_W;
    localparam int SW = bctl_pkg::SUM_W;

    logic [6:0]  len_mem [4][bctl_pkg::BANK_CORNERS];
    logic [31:0] pt_mem  [4][bctl_pkg::BANK_POINTS];
    logic [6:0]  len_rd_reg [4];
    logic [31:0] pt_rd_reg  [4];

    bctl_pkg::back_state_t state_reg;
    bctl_pkg::back_state_t state_next;
    logic [CA-1:0]         clr_cnt_reg;
    logic [CA-1:0]         clr_cnt_next;
    logic [bctl_pkg::SLOT_W-1:0] k_reg;
    logic [bctl_pkg::SLOT_W-1:0] k_next;
    logic [6:0]            n_reg;
    bctl_pkg::cmd_t        cmd_reg;
    logic [WW-1:0]         w_reg [4];
    logic [PW-1:0]         prod_x_reg [4];
    logic [PW-1:0]         prod_y_reg [4];
    logic                  result_valid_reg;
    logic                  result_valid_next;
    bctl_pkg::out_word_t   result_reg;
    bctl_pkg::out_word_t   result_next;

    logic          len_we;
    logic [3:0]    len_mask;
    logic [CA-1:0] len_waddr;
    logic [6:0]    len_wdata;
    logic          pt_we;
    logic [6:0]    n_min;
    logic [WW-1:0] w_calc [4];
    logic [31:0]   p_sel [4];
    logic [SW-1:0] sum_x;
    logic [SW-1:0] sum_y;
    logic [4:0]    sh;
    logic          out_free;
    logic          is_last;

    always_comb
    begin
        logic [6:0]  m0;
        logic [6:0]  m1;
        logic [11:0] s;
        logic [11:0] sdu;
        logic [11:0] sdv;
        logic [SW-1:0] rnd;
        m0    = (len_rd_reg[0] < len_rd_reg[1]) ? len_rd_reg[0] : len_rd_reg[1];
        m1    = (len_rd_reg[2] < len_rd_reg[3]) ? len_rd_reg[2] : len_rd_reg[3];
        n_min = (m0 < m1) ? m0 : m1;

        s   = 12'd1 << cmd_reg.frac;
        sdu = s - 12'(cmd_reg.du);
        sdv = s - 12'(cmd_reg.dv);
        w_calc[0] = WW'(sdu) * WW'(sdv);
        w_calc[1] = WW'(cmd_reg.du) * WW'(sdv);
        w_calc[2] = WW'(sdu) * WW'(cmd_reg.dv);
        w_calc[3] = WW'(cmd_reg.du) * WW'(cmd_reg.dv);

        p_sel[0] = pt_rd_reg[{cmd_reg.v0_par, cmd_reg.u0_par}];
        p_sel[1] = pt_rd_reg[{cmd_reg.v0_par, !cmd_reg.u0_par}];
        p_sel[2] = pt_rd_reg[{!cmd_reg.v0_par, cmd_reg.u0_par}];
        p_sel[3] = pt_rd_reg[{!cmd_reg.v0_par, !cmd_reg.u0_par}];

        sh    = {cmd_reg.frac, 1'b0};
        rnd   = SW'(1) << (sh - 5'd1);
        sum_x = SW'(prod_x_reg[0]) + SW'(prod_x_reg[1]) + SW'(prod_x_reg[2])
              + SW'(prod_x_reg[3]) + rnd;
        sum_y = SW'(prod_y_reg[0]) + SW'(prod_y_reg[1]) + SW'(prod_y_reg[2])
              + SW'(prod_y_reg[3]) + rnd;
    end

    always_comb
    begin
        out_free          = !result_valid_reg || result_ready;
        is_last           = (7'(k_reg) + 7'd1 == n_reg);
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        k_next            = k_reg;
        pop               = 1'b0;
        len_we            = 1'b0;
        len_mask          = 4'b0000;
        len_waddr         = head.caddr[0];
        len_wdata         = head.length;
        pt_we             = 1'b0;
        result_next       = result_reg;
        result_valid_next = result_ready ? 1'b0 : result_valid_reg;

        unique case (state_reg)
            bctl_pkg::BK_CLEAR:
            begin
                len_we    = 1'b1;
                len_mask  = 4'b1111;
                len_waddr = clr_cnt_reg;
                len_wdata = 7'd0;
                clr_cnt_next = clr_cnt_reg + CA'(1);
                if (clr_cnt_reg == CA'(bctl_pkg::BANK_CORNERS - 1))
                begin
                    state_next = bctl_pkg::BK_IDLE;
                end
            end
            bctl_pkg::BK_IDLE:
            begin
                if (fifo_stat.head_valid)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        bctl_pkg::CMD_LEN:
                        begin
                            len_we   = 1'b1;
                            len_mask = 4'b0001 << head.bank_sel;
                        end
                        bctl_pkg::CMD_PT:
                        begin
                            pt_we = 1'b1;
                        end
                        bctl_pkg::CMD_QUERY:
                        begin
                            state_next = bctl_pkg::BK_LEN;
                        end
                        bctl_pkg::CMD_MISS:
                        begin
                            state_next = bctl_pkg::BK_MISS;
                        end
                    endcase
                end
            end
            bctl_pkg::BK_LEN:
            begin
                k_next     = '0;
                state_next = (n_min == 7'd0) ? bctl_pkg::BK_MISS : bctl_pkg::BK_RD;
            end
            bctl_pkg::BK_RD:
            begin
                state_next = bctl_pkg::BK_MUL;
            end
            bctl_pkg::BK_MUL:
            begin
                state_next = bctl_pkg::BK_SUM;
            end
            bctl_pkg::BK_SUM:
            begin
                if (out_free)
                begin
                    result_valid_next  = 1'b1;
                    result_next.found  = 1'b1;
                    result_next.cand_x = 16'(sum_x >> sh);
                    result_next.cand_y = 16'(sum_y >> sh);
                    result_next.last   = is_last;
                    k_next             = k_reg + bctl_pkg::SLOT_W'(1);
                    state_next = is_last ? bctl_pkg::BK_IDLE : bctl_pkg::BK_RD;
                end
            end
            bctl_pkg::BK_MISS:
            begin
                if (out_free)
                begin
                    result_valid_next  = 1'b1;
                    result_next.found  = 1'b0;
                    result_next.cand_x = 16'd0;
                    result_next.cand_y = 16'd0;
                    result_next.last   = 1'b1;
                    state_next         = bctl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bctl_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bctl_pkg::BK_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        result_reg <= result_next;
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (state_reg == bctl_pkg::BK_LEN)
        begin
            n_reg <= n_min;
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i] <= w_calc[i];
            end
        end
        if (state_reg == bctl_pkg::BK_MUL)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_x_reg[i] <= PW'(p_sel[i][15:0]) * PW'(w_reg[i]);
                prod_y_reg[i] <= PW'(p_sel[i][31:16]) * PW'(w_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (len_we && len_mask[b])
            begin
                len_mem[b][len_waddr] <= len_wdata;
            end
            len_rd_reg[b] <= len_mem[b][head.caddr[b]];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (pt_we && head.bank_sel == 2'(b))
            begin
                pt_mem[b][{head.caddr[b], head.slot}] <= head.point;
            end
            pt_rd_reg[b] <= pt_mem[b][PA'({cmd_reg.caddr[b], k_reg})];
        end
    end

    assign clear_done   = (state_reg != bctl_pkg::BK_CLEAR);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

### design/bilinear_curve_table_lookup.sv
`timescale 1ns / 1ps

// Accepted words go through a two-word command queue to the back end. Write words are
// handled there as they leave the queue. A query leaves the queue while the four corner
// lengths are read, then the weights are formed, then each emitted point takes a banked
// point read, a multiply, and a sum and round. An out-of-range query goes straight to its
// not-found word, and an empty one reaches it after the length check. A result word that is not
// taken holds the back end, and the input stalls once the queue is full. The four corners
// of a cell always fall in four different memory banks, which is what lets one read step
// fetch all of them. After reset the length tables are cleared, all 289 corner addresses
// of each bank, and during the clear no word is accepted.

module bilinear_curve_table_lookup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  bctl_pkg::in_word_t  item,
    input  logic                item_valid,
    output logic                item_ready,
    output bctl_pkg::out_word_t result,
    output logic                result_valid,
    input  logic                result_ready
);

    logic [2:0] pyr_level_reg;
    logic [5:0] grid_width_reg;
    logic [5:0] grid_height_reg;
    logic       cfg_write;

    bctl_pkg::cfg_t       cfg;
    bctl_pkg::fifo_stat_t fifo_stat;
    bctl_pkg::cmd_t       push_cmd;
    bctl_pkg::cmd_t       head;
    logic                 push;
    logic                 pop;
    logic                 clear_done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pyr_level_reg   <= 3'd0;
            grid_width_reg  <= 6'd32;
            grid_height_reg <= 6'd32;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                bctl_pkg::REG_PYR_LEVEL:   pyr_level_reg   <= pwdata[2:0];
                bctl_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[5:0];
                bctl_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[5:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bctl_pkg::REG_PYR_LEVEL:   prdata = {29'd0, pyr_level_reg};
            bctl_pkg::REG_GRID_WIDTH:  prdata = {26'd0, grid_width_reg};
            bctl_pkg::REG_GRID_HEIGHT: prdata = {26'd0, grid_height_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.pyr_level   = pyr_level_reg;
    assign cfg.grid_width  = grid_width_reg;
    assign cfg.grid_height = grid_height_reg;

    bctl_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cfg        (cfg),
        .clear_done (clear_done),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .cmd        (push_cmd)
    );

    bctl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    bctl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .fifo_stat    (fifo_stat),
        .pop          (pop),
        .clear_done   (clear_done),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.last)
        else $error("not-found word without last");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.cand_x == 16'd0 && result.cand_y == 16'd0)
        else $error("not-found word carries a position");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !item_ready && !push)
        else $error("word accepted during table clear");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fifo_stat.head_valid)
        else $error("queue popped while empty");

endmodule
